>>> sv/bsc_pkg.sv
// ============================================================================
// bsc_pkg
// Shared types and constants of the bilinear fixed-point image scaler.
// ============================================================================
`default_nettype none

package bsc_pkg;

    // Default capacities of the frame store and of the destination size.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_DST_DEF    = 4096;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int SRC_IDX_W  = 8;
    localparam int OUT_W      = 12;
    localparam int SW_CFG_W   = 9;
    localparam int DW_CFG_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

    localparam int SIZE_RESET = 256;
    localparam int MIN_SIZE   = 2;

    // Input item kinds.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EMIT = 1'b1;

    // 9.16 fixed point.
    localparam int FRAC_W = 16;
    localparam int POS_W  = 25;
    localparam int STEP_W = 24;
    localparam int INT_W  = POS_W - FRAC_W;
    localparam logic [POS_W-1:0] POS_HALF = 25'h0008000;

    // Step fraction bits that decide the half-pixel start.
    localparam int CHK_HI = 15;
    localparam int CHK_LO = 11;

    // Interpolation weights.
    localparam int WT_W       = 3;
    localparam int WW_W       = WT_W + 1;
    localparam int WT_SUM     = 8;
    localparam int WY_SCALE   = 1024;
    localparam int WY_W       = $clog2(WT_SUM * WY_SCALE + 1);
    localparam int HV_W       = PIX_W + WT_W;
    localparam int BL_W       = HV_W + WY_W + 1;
    localparam int ROUND_BIAS = 32'h8000;

    // Neighbour select codes: row then column.
    localparam logic [1:0] NB_00 = 2'b00;
    localparam logic [1:0] NB_01 = 2'b01;
    localparam logic [1:0] NB_10 = 2'b10;
    localparam logic [1:0] NB_11 = 2'b11;

    typedef struct packed {
        logic       load_wr;
        logic       div_go;
        logic       div_y;
        logic       div_minus2;
        logic       x_step_ld;
        logic       y_step_ld;
        logic       half;
        logic       rd_en;
        logic [1:0] rd_nb;
        logic       cap_p00;
        logic       cap_v0;
        logic       cap_p10;
        logic       cap_v1;
        logic       finish;
    } bsc_cmd_t;

    typedef struct packed {
        logic steps_ready;
        logic div_done;
        logic step_low_zero;
        logic height_same;
    } bsc_sts_t;

endpackage

`default_nettype wire

>>> sv/bsc_div.sv
// ============================================================================
// bsc_div
// Restoring divider, one quotient bit per cycle, used for the frame steps.
// ============================================================================
`default_nettype none

module bsc_div
    import bsc_pkg::*;
#(
    parameter int NUM_W = 25,
    parameter int DV_W  = 12
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DV_W-1:0]  den,
    output logic      [NUM_W-1:0] quo,
    output logic                  done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DV_W-1:0]  rem_reg;
    logic [DV_W-1:0]  rem_next;
    logic [DV_W-1:0]  den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DV_W:0]    trial;
    logic             fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? DV_W'(trial - {1'b0, den_reg}) : DV_W'(trial);
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (go)
        begin
            cnt_reg  <= CNT_W'(NUM_W);
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // The numerator shifts out of the top of quo_reg while quotient bits enter below.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

>>> sv/bsc_dp.sv
// ============================================================================
// bsc_dp
// Scaler datapath: configuration, frame store, positions and pixel blending.
// ============================================================================
`default_nettype none

module bsc_dp
    import bsc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_DST    = MAX_DST_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bsc_cmd_t              cmd,
    output bsc_sts_t                   sts,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [SRC_IDX_W-1:0]  src_col,
    input  wire logic [SRC_IDX_W-1:0]  src_row,
    input  wire logic [PIX_W-1:0]      src_pixel,
    output logic                       done,
    output logic      [PIX_W-1:0]      out_pixel,
    output logic      [OUT_W-1:0]      out_col,
    output logic      [OUT_W-1:0]      out_row,
    output logic                       row_end,
    output logic                       frame_end
);

    localparam int CW_W  = $clog2(MAX_WIDTH + 1);
    localparam int CH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SRC_W = (CW_W > CH_W) ? CW_W : CH_W;
    localparam int DW_W  = $clog2(MAX_DST + 1);
    localparam int DV_W  = $clog2(MAX_DST);
    localparam int NUM_W = SRC_W + FRAC_W;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int IX_W  = ((INT_W > SRC_W) ? INT_W : SRC_W) + 1;
    localparam longint DEPTH  = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int     ADDR_W = $clog2(DEPTH);

    // Configuration registers.
    logic [SW_CFG_W-1:0] src_width_reg;
    logic [SW_CFG_W-1:0] src_height_reg;
    logic [DW_CFG_W-1:0] dst_width_reg;
    logic [DW_CFG_W-1:0] dst_height_reg;

    // Frame walk state.
    logic [POS_W-1:0]  x_pos_reg;
    logic [POS_W-1:0]  y_pos_reg;
    logic [STEP_W-1:0] x_step_reg;
    logic [STEP_W-1:0] y_step_reg;
    logic              x_half_reg;
    logic [DW_W-1:0]   col_reg;
    logic [DW_W-1:0]   row_reg;
    logic              steps_ready_reg;

    // Pixel pipeline.
    logic [PIX_W-1:0] store_mem [DEPTH];
    logic [PIX_W-1:0] rd_q_reg;
    logic [PIX_W-1:0] p00_reg;
    logic [PIX_W-1:0] p10_reg;
    logic [HV_W-1:0]  v0_reg;
    logic [HV_W-1:0]  v1_reg;

    // Result registers.
    logic             done_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic [OUT_W-1:0] out_col_reg;
    logic [OUT_W-1:0] out_row_reg;
    logic             row_end_reg;
    logic             frame_end_reg;

    logic [CW_W-1:0]  sw;
    logic [CH_W-1:0]  sh;
    logic [DW_W-1:0]  dw;
    logic [DW_W-1:0]  dh;
    logic [SRC_W-1:0] src_sel;
    logic [SRC_W-1:0] src_adj;
    logic [NUM_W-1:0] div_num;
    logic [DV_W-1:0]  div_den;
    logic [NUM_W-1:0] div_quo;
    logic             div_done;
    logic             cfg_hit;

    logic [IX_W-1:0]   xs;
    logic [IX_W-1:0]   ys;
    logic [IX_W-1:0]   last_c;
    logic [IX_W-1:0]   last_r;
    logic [IX_W-1:0]   x0;
    logic [IX_W-1:0]   x1;
    logic [IX_W-1:0]   r0;
    logic [IX_W-1:0]   r1;
    logic [COL_W-1:0]  col_idx;
    logic [ROW_W-1:0]  row_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] ld_addr;
    logic [ADDR_W-1:0] mem_addr;
    logic              ld_ok;
    logic              mem_we;

    logic [WT_W-1:0]       wx2;
    logic [WW_W-1:0]       wx1;
    logic [WT_W-1:0]       wy;
    logic [WY_W-1:0]       wy2;
    logic [WY_W-1:0]       wy1;
    logic [PIX_W-1:0]      h_left;
    logic [PIX_W+WW_W-1:0] h_t0;
    logic [PIX_W+WW_W-1:0] h_t1;
    logic [HV_W-1:0]       h_sum;
    logic [BL_W-1:0]       b_sum;

    logic [DW_W-1:0]  col_next;
    logic [DW_W-1:0]  row_next;

    // Sizes are saturated into their legal ranges when used.
    always_comb
    begin
        if (src_width_reg < MIN_SIZE)
            sw = CW_W'(MIN_SIZE);
        else if (32'(src_width_reg) > MAX_WIDTH)
            sw = CW_W'(MAX_WIDTH);
        else
            sw = CW_W'(src_width_reg);

        if (src_height_reg < MIN_SIZE)
            sh = CH_W'(MIN_SIZE);
        else if (32'(src_height_reg) > MAX_HEIGHT)
            sh = CH_W'(MAX_HEIGHT);
        else
            sh = CH_W'(src_height_reg);

        if (dst_width_reg < MIN_SIZE)
            dw = DW_W'(MIN_SIZE);
        else if (32'(dst_width_reg) > MAX_DST)
            dw = DW_W'(MAX_DST);
        else
            dw = DW_W'(dst_width_reg);

        if (dst_height_reg < MIN_SIZE)
            dh = DW_W'(MIN_SIZE);
        else if (32'(dst_height_reg) > MAX_DST)
            dh = DW_W'(MAX_DST);
        else
            dh = DW_W'(dst_height_reg);
    end

    // Step division operands: ((src - 1 or 2) << 16) / (dst - 1).
    always_comb
    begin
        src_sel = cmd.div_y ? SRC_W'(sh) : SRC_W'(sw);
        src_adj = cmd.div_minus2 ? (src_sel - SRC_W'(MIN_SIZE)) : (src_sel - SRC_W'(1));
        div_num = {src_adj, {FRAC_W{1'b0}}};
        div_den = cmd.div_y ? DV_W'(dh - DW_W'(1)) : DV_W'(dw - DW_W'(1));
    end

    bsc_div #(
        .NUM_W (NUM_W),
        .DV_W  (DV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.div_go),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    assign sts.steps_ready   = steps_ready_reg;
    assign sts.div_done      = div_done;
    assign sts.step_low_zero = (div_quo[CHK_HI:CHK_LO] == '0);
    assign sts.height_same   = (32'(sh) == 32'(dh));

    // Neighbour coordinates; a neighbour past the edge is clamped to the last one.
    always_comb
    begin
        xs     = IX_W'(x_pos_reg[POS_W-1:FRAC_W]);
        ys     = IX_W'(y_pos_reg[POS_W-1:FRAC_W]);
        last_c = IX_W'(sw) - IX_W'(1);
        last_r = IX_W'(sh) - IX_W'(1);
        wx2    = x_pos_reg[FRAC_W-1 -: WT_W];
        wx1    = WW_W'(WT_SUM) - WW_W'(wx2);
        wy     = y_pos_reg[FRAC_W-1 -: WT_W];
        x0     = (xs < last_c) ? xs : last_c;
        x1     = ((xs + IX_W'(1)) < last_c) ? (xs + IX_W'(1)) : last_c;
        r0     = (ys < last_r) ? ys : last_r;
        if (wy == '0)
            r1 = r0;
        else
            r1 = ((ys + IX_W'(1)) < last_r) ? (ys + IX_W'(1)) : last_r;

        unique case (cmd.rd_nb)
            NB_00:
            begin
                row_idx = ROW_W'(r0);
                col_idx = COL_W'(x0);
            end
            NB_01:
            begin
                row_idx = ROW_W'(r0);
                col_idx = COL_W'(x1);
            end
            NB_10:
            begin
                row_idx = ROW_W'(r1);
                col_idx = COL_W'(x0);
            end
            default:
            begin
                row_idx = ROW_W'(r1);
                col_idx = COL_W'(x1);
            end
        endcase

        rd_addr = ADDR_W'(longint'(row_idx) * longint'(MAX_WIDTH) + longint'(col_idx));
        ld_addr = ADDR_W'(longint'(src_row) * longint'(MAX_WIDTH) + longint'(src_col));
        ld_ok   = (32'(src_col) < MAX_WIDTH) && (32'(src_row) < MAX_HEIGHT);
        mem_we  = cmd.load_wr && ld_ok;
        mem_addr = cmd.load_wr ? ld_addr : rd_addr;
    end

    // Single-port frame store with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= src_pixel;
        if (cmd.rd_en)
            rd_q_reg <= store_mem[mem_addr];
    end

    // Horizontal mix of a left pixel with the right pixel now on the read port.
    always_comb
    begin
        h_left = cmd.cap_v1 ? p10_reg : p00_reg;
        h_t0   = h_left * wx1;
        h_t1   = rd_q_reg * wx2;
        h_sum  = HV_W'(h_t0 + h_t1);
    end

    // Vertical blend with weights scaled by 1024, rounded at bit 16.
    always_comb
    begin
        wy2   = WY_W'(32'(wy) * WY_SCALE);
        wy1   = WY_W'(WT_SUM * WY_SCALE) - wy2;
        b_sum = BL_W'(v0_reg) * BL_W'(wy1) + BL_W'(v1_reg) * BL_W'(wy2)
              + BL_W'(ROUND_BIAS);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_p00)
            p00_reg <= rd_q_reg;
        if (cmd.cap_p10)
            p10_reg <= rd_q_reg;
        if (cmd.cap_v0)
            v0_reg <= h_sum;
        if (cmd.cap_v1)
            v1_reg <= h_sum;
        if (cmd.finish)
        begin
            out_pixel_reg <= b_sum[FRAC_W +: PIX_W];
            out_col_reg   <= OUT_W'(col_reg);
            out_row_reg   <= OUT_W'(row_reg);
            row_end_reg   <= (col_next >= dw);
            frame_end_reg <= (col_next >= dw) && (row_next >= dh);
        end
    end

    assign col_next = col_reg + DW_W'(1);
    assign row_next = row_reg + DW_W'(1);

    always_comb
    begin
        unique case (cfg_index)
            REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT:
                cfg_hit = cfg_we;
            default:
                cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= SW_CFG_W'(SIZE_RESET);
            src_height_reg  <= SW_CFG_W'(SIZE_RESET);
            dst_width_reg   <= DW_CFG_W'(SIZE_RESET);
            dst_height_reg  <= DW_CFG_W'(SIZE_RESET);
            x_pos_reg       <= '0;
            y_pos_reg       <= '0;
            x_step_reg      <= '0;
            y_step_reg      <= '0;
            x_half_reg      <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            steps_ready_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;

            if (cfg_hit)
            begin
                unique case (cfg_index)
                    REG_SRC_WIDTH:  src_width_reg  <= SW_CFG_W'(cfg_data);
                    REG_SRC_HEIGHT: src_height_reg <= SW_CFG_W'(cfg_data);
                    REG_DST_WIDTH:  dst_width_reg  <= DW_CFG_W'(cfg_data);
                    default:        dst_height_reg <= DW_CFG_W'(cfg_data);
                endcase
                // A new size restarts the frame on the next emit.
                steps_ready_reg <= 1'b0;
                col_reg         <= '0;
                row_reg         <= '0;
            end

            if (cmd.x_step_ld)
            begin
                x_step_reg <= STEP_W'(div_quo);
                x_half_reg <= cmd.half;
            end

            // The vertical step is the last one found, so the frame starts here.
            if (cmd.y_step_ld)
            begin
                y_step_reg      <= STEP_W'(div_quo);
                y_pos_reg       <= cmd.half ? POS_HALF : '0;
                x_pos_reg       <= x_half_reg ? POS_HALF : '0;
                col_reg         <= '0;
                row_reg         <= '0;
                steps_ready_reg <= 1'b1;
            end

            if (cmd.finish)
            begin
                if (col_next >= dw)
                begin
                    col_reg   <= '0;
                    x_pos_reg <= x_half_reg ? POS_HALF : '0;
                    y_pos_reg <= y_pos_reg + POS_W'(y_step_reg);
                    if (row_next >= dh)
                    begin
                        row_reg         <= '0;
                        steps_ready_reg <= 1'b0;
                    end
                    else
                    begin
                        row_reg <= row_next;
                    end
                end
                else
                begin
                    col_reg   <= col_next;
                    x_pos_reg <= x_pos_reg + POS_W'(x_step_reg);
                end
            end
        end
    end

    assign done      = done_reg;
    assign out_pixel = out_pixel_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

`default_nettype wire

>>> sv/bsc_ctrl.sv
// ============================================================================
// bsc_ctrl
// Scaler controller: loads, step divisions at frame start, four store reads per pixel.
// ============================================================================
`default_nettype none

module bsc_ctrl
    import bsc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     action,
    input  wire bsc_sts_t sts,
    output bsc_cmd_t      cmd,
    output logic          busy
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DX1  = 4'd1;
    localparam logic [3:0] S_WX1  = 4'd2;
    localparam logic [3:0] S_DX2  = 4'd3;
    localparam logic [3:0] S_WX2  = 4'd4;
    localparam logic [3:0] S_DY1  = 4'd5;
    localparam logic [3:0] S_WY1  = 4'd6;
    localparam logic [3:0] S_DY2  = 4'd7;
    localparam logic [3:0] S_WY2  = 4'd8;
    localparam logic [3:0] S_RD0  = 4'd9;
    localparam logic [3:0] S_RD1  = 4'd10;
    localparam logic [3:0] S_RD2  = 4'd11;
    localparam logic [3:0] S_RD3  = 4'd12;
    localparam logic [3:0] S_MIX  = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_LOAD)
                        cmd.load_wr = 1'b1;
                    else if (sts.steps_ready)
                        state_next = S_RD0;
                    else
                        state_next = S_DX1;
                end
            end
            S_DX1:
            begin
                cmd.div_go = 1'b1;
                state_next = S_WX1;
            end
            S_WX1:
            begin
                if (sts.div_done)
                begin
                    if (sts.step_low_zero)
                    begin
                        state_next = S_DX2;
                    end
                    else
                    begin
                        cmd.x_step_ld = 1'b1;
                        state_next    = S_DY1;
                    end
                end
            end
            S_DX2:
            begin
                cmd.div_go     = 1'b1;
                cmd.div_minus2 = 1'b1;
                state_next     = S_WX2;
            end
            S_WX2:
            begin
                if (sts.div_done)
                begin
                    cmd.x_step_ld = 1'b1;
                    cmd.half      = 1'b1;
                    state_next    = S_DY1;
                end
            end
            S_DY1:
            begin
                cmd.div_go = 1'b1;
                cmd.div_y  = 1'b1;
                state_next = S_WY1;
            end
            S_WY1:
            begin
                if (sts.div_done)
                begin
                    // The vertical half-pixel start applies only when the heights differ.
                    if (!sts.height_same && sts.step_low_zero)
                    begin
                        state_next = S_DY2;
                    end
                    else
                    begin
                        cmd.y_step_ld = 1'b1;
                        state_next    = S_RD0;
                    end
                end
            end
            S_DY2:
            begin
                cmd.div_go     = 1'b1;
                cmd.div_y      = 1'b1;
                cmd.div_minus2 = 1'b1;
                state_next     = S_WY2;
            end
            S_WY2:
            begin
                if (sts.div_done)
                begin
                    cmd.y_step_ld = 1'b1;
                    cmd.half      = 1'b1;
                    state_next    = S_RD0;
                end
            end
            S_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_nb  = NB_00;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_nb   = NB_01;
                cmd.cap_p00 = 1'b1;
                state_next  = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_nb  = NB_10;
                cmd.cap_v0 = 1'b1;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_nb   = NB_11;
                cmd.cap_p10 = 1'b1;
                state_next  = S_MIX;
            end
            S_MIX:
            begin
                cmd.cap_v1 = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

>>> sv/bilinear_scaler_fixed_point_top.sv
// ============================================================================
// bilinear_scaler_fixed_point_top
// Bilinear scaler of one 8-bit plane in 9.16 fixed point.
// ============================================================================
// Items enter on start while busy is low. A load (action low) writes src_pixel
// into the frame store at src_row, src_col in the same cycle and leaves busy
// low, so loads go at one per cycle. An emit (action high) produces the next
// destination pixel in raster order: done pulses for one cycle with out_pixel,
// out_col, out_row, row_end and frame_end once the controller has gone through
// its states RD0 to RD3, MIX and FIN after the start transaction, and busy is
// high while it does so. The four neighbours come from the single-port store
// one read per cycle. The first emit of a frame also runs two to four step
// divisions on the shared one-bit-per-cycle divider before the reads begin.
// Register writes go through cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is low while busy. A write restarts the frame on the next emit.
// Reset clears the controller and the frame walk and sets all sizes to 256;
// the frame store keeps no reset value and must be loaded before use.
// Results cannot be held off: done is a plain one-cycle strobe.
// ============================================================================
`default_nettype none

module bilinear_scaler_fixed_point_top
    import bsc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_DST    = MAX_DST_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  action,
    input  wire logic [SRC_IDX_W-1:0]  src_col,
    input  wire logic [SRC_IDX_W-1:0]  src_row,
    input  wire logic [PIX_W-1:0]      src_pixel,
    output logic                       done,
    output logic      [PIX_W-1:0]      out_pixel,
    output logic      [OUT_W-1:0]      out_col,
    output logic      [OUT_W-1:0]      out_row,
    output logic                       row_end,
    output logic                       frame_end,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    bsc_cmd_t cmd;
    bsc_sts_t sts;
    logic     cfg_we;

    assign cfg_ready = ~busy;
    assign cfg_we    = cfg_valid & cfg_ready;

    bsc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    bsc_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_DST    (MAX_DST)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_col   (src_col),
        .src_row   (src_row),
        .src_pixel (src_pixel),
        .done      (done),
        .out_pixel (out_pixel),
        .out_col   (out_col),
        .out_row   (out_row),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

endmodule

`default_nettype wire
